@@ design/bcd_pkg.sv @@
// shared types and constants for the button click and hold detector
package bcd_pkg;

  // event codes carried on the result channel
  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_SINGLE  = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_TRIPLE  = 3'd4,
    EV_QUAD    = 3'd5,
    EV_FIVE    = 3'd6,
    EV_LONG    = 3'd7
  } event_e;

  // configuration register indexes
  localparam logic [1:0] REG_BURST_WAIT = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [1:0] REG_HOLD_CAP   = 2'd2;
  localparam logic [1:0] REG_SUPPRESS   = 2'd3;

  // register reset values
  localparam logic [9:0] BURST_WAIT_RST = 10'd70;
  localparam logic [9:0] LONG_PRESS_RST = 10'd300;
  localparam logic [9:0] HOLD_CAP_RST   = 10'd1000;

  localparam logic [2:0] CLICK_MAX = 3'd7;
  localparam logic [2:0] CLICK_FIVE = 3'd5;

  typedef struct packed {
    logic [9:0] burst_wait;
    logic [9:0] long_press;
    logic [9:0] hold_cap;
    logic       suppress;
  } cfg_t;

  typedef struct packed {
    logic       prev_pressed;
    logic       debounce_seen;
    logic       conf_pressed;
    logic       rep_pressed;
    logic [9:0] hold_count;
    logic [2:0] click_count;
    logic [9:0] burst_timer;
  } state_t;

  typedef struct packed {
    event_e     code;
    logic [9:0] hold;
    logic       last;
  } result_t;

endpackage

@@ design/button_click_and_hold_detector.sv @@
// top level of the button click and hold detector
//
// channel   direction  handshake                   payload
// tick      in         in_valid_i / in_stall_o     button_level_i
// event     out        out_valid_o / out_stall_i   event_code_o, hold_ticks_o, last_of_tick_o
// config    in         psel / penable / pwrite     paddr, pwdata, prdata
//
// a tick is taken into the input register, and the state update then writes its zero
// to two events into a four-entry queue; events leave one per cycle while the receiver
// does not stall, and the sustained rate is one tick per cycle while each tick causes one
// event, lower when ticks cause two. the input register holds while the queue lacks
// room for two events. reset restores register defaults.
module button_click_and_hold_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        button_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_code_o,
  output logic [9:0]  hold_ticks_o,
  output logic        last_of_tick_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcd_pkg::*;

  cfg_t          cfg_q, cfg_d;
  state_t        state_q, state_d, state_nx;
  logic          in_valid_q, in_valid_d;
  logic          level_q;
  logic          load;
  logic          drain;
  logic          space2;
  logic          suppress_clr;
  logic [1:0]    res_cnt;
  logic [1:0]    push_cnt;
  result_t [1:0] res;
  result_t       head;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // input register handshake
  assign drain      = in_valid_q && space2;
  assign in_stall_o = in_valid_q && !space2;
  assign load       = in_valid_i && !in_stall_o;
  assign in_valid_d = load || (in_valid_q && !drain);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      level_q <= button_level_i;
    end
  end

  // tick update
  bcd_step u_step (
    .level_i        (level_q),
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .state_o        (state_nx),
    .suppress_clr_o (suppress_clr),
    .res_cnt_o      (res_cnt),
    .res_o          (res)
  );

  assign state_d  = drain ? state_nx : state_q;
  assign push_cnt = drain ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (drain && suppress_clr) begin
      cfg_d.suppress = 1'b0;
    end
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_BURST_WAIT: cfg_d.burst_wait = pwdata[9:0];
        REG_LONG_PRESS: cfg_d.long_press = pwdata[9:0];
        REG_HOLD_CAP:   cfg_d.hold_cap   = pwdata[9:0];
        REG_SUPPRESS:   cfg_d.suppress   = pwdata[0];
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.burst_wait <= BURST_WAIT_RST;
      cfg_q.long_press <= LONG_PRESS_RST;
      cfg_q.hold_cap   <= HOLD_CAP_RST;
      cfg_q.suppress   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_BURST_WAIT: prdata = {22'd0, cfg_q.burst_wait};
      REG_LONG_PRESS: prdata = {22'd0, cfg_q.long_press};
      REG_HOLD_CAP:   prdata = {22'd0, cfg_q.hold_cap};
      REG_SUPPRESS:   prdata = {31'd0, cfg_q.suppress};
      default:        prdata = '0;
    endcase
  end

  // result queue
  bcd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_data_i (res),
    .space2_o    (space2),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (head)
  );

  assign event_code_o   = head.code;
  assign hold_ticks_o   = head.hold;
  assign last_of_tick_o = head.last;

endmodule

@@ design/bcd_step.sv @@
// per-tick update of the detector state and the results of one tick
module bcd_step (
  input  logic                   level_i,
  input  bcd_pkg::cfg_t          cfg_i,
  input  bcd_pkg::state_t        state_i,
  output bcd_pkg::state_t        state_o,
  output logic                   suppress_clr_o,
  output logic [1:0]             res_cnt_o,
  output bcd_pkg::result_t [1:0] res_o
);
  import bcd_pkg::*;

  logic        changed;
  logic [10:0] hold_inc;
  logic [1:0]  n;

  always_comb begin
    state_o        = state_i;
    suppress_clr_o = 1'b0;
    changed        = 1'b0;
    n              = 2'd0;
    hold_inc       = {1'b0, state_i.hold_count} + 11'd1;
    res_o          = '0;

    // burst timer countdown and multi-click report
    if (state_i.burst_timer != '0) begin
      state_o.burst_timer = state_i.burst_timer - 10'd1;
      if (state_o.burst_timer == '0) begin
        if (state_i.click_count >= 3'd1 && state_i.click_count <= 3'd4) begin
          // single click code sits one above a click count of one
          res_o[n[0]].code = event_e'(state_i.click_count + 3'd1);
          n = n + 2'd1;
        end
        state_o.click_count = '0;
      end
    end

    // debounce
    if (!level_i) begin
      state_o.conf_pressed  = 1'b0;
      state_o.prev_pressed  = 1'b0;
      state_o.debounce_seen = 1'b0;
      changed               = state_i.rep_pressed;
    end else if (!state_i.prev_pressed) begin
      state_o.prev_pressed  = 1'b1;
      state_o.debounce_seen = 1'b0;
    end else if (!state_i.debounce_seen) begin
      state_o.debounce_seen = 1'b1;
      state_o.conf_pressed  = 1'b1;
      changed               = 1'b1;
    end

    // press, release and hold handling
    if (changed) begin
      if (state_o.conf_pressed) begin
        res_o[n[0]].code = EV_PRESS;
        n = n + 2'd1;
        if (state_o.click_count < CLICK_MAX) begin
          state_o.click_count = state_o.click_count + 3'd1;
          if (state_o.click_count == CLICK_FIVE) begin
            res_o[n[0]].code = EV_FIVE;
            n = n + 2'd1;
          end
        end
      end else begin
        if (!cfg_i.suppress) begin
          res_o[n[0]].code = EV_RELEASE;
          res_o[n[0]].hold = state_i.hold_count;
          n = n + 2'd1;
        end
        state_o.burst_timer = cfg_i.burst_wait;
        state_o.hold_count  = '0;
        suppress_clr_o      = 1'b1;
      end
      state_o.rep_pressed = state_o.conf_pressed;
    end else if (state_o.conf_pressed) begin
      if (hold_inc > {1'b0, cfg_i.hold_cap}) begin
        state_o.hold_count = cfg_i.hold_cap;
      end else begin
        state_o.hold_count = hold_inc[9:0];
        if (hold_inc == {1'b0, cfg_i.long_press}) begin
          res_o[n[0]].code    = EV_LONG;
          n                   = n + 2'd1;
          state_o.click_count = '0;
          state_o.burst_timer = '0;
        end
      end
    end else begin
      state_o.hold_count = '0;
    end

    // mark the final result of the tick
    if (n != 2'd0) begin
      res_o[n[1]].last = 1'b1;
    end
  end

  assign res_cnt_o = n;

endmodule

@@ design/bcd_outq.sv @@
// four-entry result queue, two writes and one read per cycle
module bcd_outq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             push_cnt_i,
  input  bcd_pkg::result_t [1:0] push_data_i,
  output logic                   space2_o,
  output logic                   valid_o,
  input  logic                   stall_i,
  output bcd_pkg::result_t       data_o
);
  import bcd_pkg::*;

  result_t    entry_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign valid_o  = count_q != 3'd0;
  assign data_o   = entry_q[rd_ptr_q];
  assign pop      = valid_o && !stall_i;
  assign space2_o = count_q <= 3'd2;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + push_cnt_i;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    count_d  = count_q + {1'b0, push_cnt_i} - {2'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entry_q[wr_ptr_q] <= push_data_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      entry_q[wr_ptr_q + 2'd1] <= push_data_i[1];
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the button click and hold detector
module testbench;
  import bcd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        button_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  event_code_o;
  logic [9:0]  hold_ticks_o;
  logic        last_of_tick_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // detector mirror: register copy, internal state and events still owed
  cfg_t        dut_cfg;
  state_t      btn;
  result_t     expected_events[$];
  int unsigned errors = 0;
  bit          idling_on = 1'b1;

  button_click_and_hold_detector uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_code_o   (event_code_o),
    .hold_ticks_o   (hold_ticks_o),
    .last_of_tick_o (last_of_tick_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // reset, held low and then released
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // one scan tick through the detector, appending the events it owes
  task automatic advance_detector(input logic level);
    result_t     evs[$];
    logic        changed;
    logic [10:0] hold_next;
    changed = 1'b0;
    // burst timer countdown and multi-click report
    if (btn.burst_timer != 10'd0) begin
      btn.burst_timer = btn.burst_timer - 10'd1;
      if (btn.burst_timer == 10'd0) begin
        if (btn.click_count >= 3'd1 && btn.click_count <= 3'd4)
          evs.push_back('{event_e'(EV_SINGLE + btn.click_count - 3'd1), 10'd0, 1'b0});
        btn.click_count = 3'd0;
      end
    end
    // debounce: two pressed samples in a row confirm a press
    if (!level) begin
      btn.conf_pressed = 1'b0;
      btn.prev_pressed = 1'b0;
      btn.debounce_seen = 1'b0;
      changed = btn.rep_pressed;
    end else if (!btn.prev_pressed) begin
      btn.prev_pressed = 1'b1;
      btn.debounce_seen = 1'b0;
    end else if (!btn.debounce_seen) begin
      btn.debounce_seen = 1'b1;
      btn.conf_pressed = 1'b1;
      changed = 1'b1;
    end
    // press, release or hold counting
    if (changed) begin
      if (btn.conf_pressed) begin
        evs.push_back('{EV_PRESS, 10'd0, 1'b0});
        if (btn.click_count < CLICK_MAX) begin
          btn.click_count = btn.click_count + 3'd1;
          if (btn.click_count == CLICK_FIVE)
            evs.push_back('{EV_FIVE, 10'd0, 1'b0});
        end
      end else begin
        if (!dut_cfg.suppress)
          evs.push_back('{EV_RELEASE, btn.hold_count, 1'b0});
        btn.burst_timer = dut_cfg.burst_wait;
        btn.hold_count = 10'd0;
        dut_cfg.suppress = 1'b0;
      end
      btn.rep_pressed = btn.conf_pressed;
    end else if (btn.conf_pressed) begin
      hold_next = {1'b0, btn.hold_count} + 11'd1;
      if (hold_next > {1'b0, dut_cfg.hold_cap}) begin
        btn.hold_count = dut_cfg.hold_cap;
      end else begin
        btn.hold_count = hold_next[9:0];
        if (btn.hold_count == dut_cfg.long_press) begin
          evs.push_back('{EV_LONG, 10'd0, 1'b0});
          btn.click_count = 3'd0;
          btn.burst_timer = 10'd0;
        end
      end
    end else begin
      btn.hold_count = 10'd0;
    end
    if (evs.size() > 0)
      evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i])
      expected_events.push_back(evs[i]);
  endtask

  // send one tick transaction, with an occasional idle burst ahead of it
  task automatic send_tick(input logic level);
    int unsigned gap;
    if (idling_on && $urandom_range(7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    button_level_i <= level;
    do @(posedge clk_i); while (in_stall_o);
    advance_detector(level);
  endtask

  // fixed level sequence, oldest tick in the msb
  task automatic send_levels(input logic [15:0] levels, input int unsigned count);
    for (int i = count - 1; i >= 0; i--)
      send_tick(levels[i]);
  endtask

  // stop sending and wait until every owed event has come out
  task automatic drain_events();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_events.size() != 0);
  endtask

  // apb write: setup phase, access phase, then an idle phase
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_BURST_WAIT: dut_cfg.burst_wait = value[9:0];
      REG_LONG_PRESS: dut_cfg.long_press = value[9:0];
      REG_HOLD_CAP:   dut_cfg.hold_cap = value[9:0];
      REG_SUPPRESS:   dut_cfg.suppress = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // registers change only once the block has gone quiet
  task automatic configure(input logic [9:0] burst, input logic [9:0] long_press,
                           input logic [9:0] cap, input logic suppress);
    drain_events();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_BURST_WAIT, 32'(burst));
    write_reg(REG_LONG_PRESS, 32'(long_press));
    write_reg(REG_HOLD_CAP, 32'(cap));
    write_reg(REG_SUPPRESS, 32'(suppress));
  endtask

  // random ticks: mostly clean clicks and holds, some debounce noise
  task automatic run_ticks(input int unsigned count);
    int unsigned sent;
    int unsigned mode;
    int unsigned press_len;
    int unsigned rel_len;
    int unsigned upper;
    sent = 0;
    while (sent < count) begin
      mode = $urandom_range(99);
      if (mode < 15) begin
        press_len = $urandom_range(1, 6);
        for (int k = 0; k < press_len && sent < count; k++) begin
          send_tick(1'($urandom_range(1)));
          sent++;
        end
      end else begin
        if (mode < 70) begin
          press_len = $urandom_range(2, 4);
        end else begin
          upper = (dut_cfg.long_press > dut_cfg.hold_cap) ? dut_cfg.long_press
                                                          : dut_cfg.hold_cap;
          press_len = $urandom_range(2, upper + 4);
        end
        if ($urandom_range(2) == 0)
          rel_len = $urandom_range(1, dut_cfg.burst_wait + 3);
        else
          rel_len = $urandom_range(1, 2);
        for (int k = 0; k < press_len && sent < count; k++) begin
          send_tick(1'b1);
          sent++;
        end
        for (int k = 0; k < rel_len && sent < count; k++) begin
          send_tick(1'b0);
          sent++;
        end
      end
    end
  endtask

  // two clicks, second press while the burst timer runs, then expiry
  task automatic test_double_click();
    configure(10'd4, 10'd3, 10'd1023, 1'b0);
    send_levels(16'b1101100000, 10);
  endtask

  // hold to the long press, then release with the click count cleared
  task automatic test_long_press();
    send_levels(16'b1111100000, 10);
  endtask

  task automatic test_random_phase(input logic [9:0] burst, input logic [9:0] long_press,
                                   input logic [9:0] cap, input logic suppress,
                                   input int unsigned count);
    configure(burst, long_press, cap, suppress);
    run_ticks(count);
  endtask

  // sender holds off until all owed events are out, then resumes
  task automatic test_pressure_pause();
    configure(10'd6, 10'd9, 10'd30, 1'b0);
    run_ticks(70);
    drain_events();
    run_ticks(70);
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_tail();
    idling_on = 1'b0;
    configure(10'd5, 10'd8, 10'd12, 1'b1);
    run_ticks(280);
  endtask

  // stimulus sequence
  initial begin
    btn = '0;
    dut_cfg = '{BURST_WAIT_RST, LONG_PRESS_RST, HOLD_CAP_RST, 1'b0};
    @(posedge rst_ni);
    @(posedge clk_i);
    test_double_click();
    test_long_press();
    test_random_phase(10'd4, 10'd6, 10'd1023, 1'b1, 220);
    test_random_phase(BURST_WAIT_RST, LONG_PRESS_RST, HOLD_CAP_RST, 1'b0, 330);
    test_random_phase(10'd1, 10'd2, 10'd1, 1'b0, 120);
    test_random_phase(10'd0, 10'd1, 10'd5, 1'b1, 120);
    test_random_phase(10'd1023, 10'd1023, 10'd1023, 1'b0, 120);
    test_random_phase(10'd3, 10'd0, 10'd0, 1'b1, 100);
    test_pressure_pause();
    test_steady_tail();
    drain_events();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("** button_click_and_hold_detector: PASSED **");
    end else begin
      $display("** button_click_and_hold_detector: FAILED **");
    end
    $finish;
  end

  // event receiver stalls in random bursts
  always @(posedge clk_i) begin : stall_gen
    int unsigned stall_left;
    if (stall_left > 0)
      stall_left--;
    else if (idling_on && rst_ni && $urandom_range(11) == 0)
      stall_left = $urandom_range(1, 14);
    out_stall_i <= (stall_left > 0);
  end

  // compare each event transaction with the oldest owed event
  always @(posedge clk_i) begin : event_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event code %0d hold %0d last %0d", $time,
                 event_code_o, hold_ticks_o, last_of_tick_o);
        errors++;
      end else begin
        want = expected_events.pop_front();
        if (event_code_o !== want.code) begin
          $display("%0t: event_code expected %0d got %0d", $time, want.code, event_code_o);
          errors++;
        end
        if (hold_ticks_o !== want.hold) begin
          $display("%0t: hold_ticks expected %0d got %0d", $time, want.hold, hold_ticks_o);
          errors++;
        end
        if (last_of_tick_o !== want.last) begin
          $display("%0t: last_of_tick expected %0d got %0d", $time, want.last,
                   last_of_tick_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("** button_click_and_hold_detector: FAILED **");
    $finish;
  end

endmodule

@@ button_click_and_hold_detector.f @@
design/bcd_pkg.sv
design/bcd_step.sv
design/bcd_outq.sv
design/button_click_and_hold_detector.sv
tb/sv/testbench.sv
